@@ hdl/spq_pkg.sv @@
// Shared types and constants of the scale pitch quantizer.
`timescale 1ns / 1ps

package spq_pkg;

   localparam int MaxNotes   = 16;
   localparam int DigitW     = 4;
   localparam int CountW     = 5;
   localparam int TotalW     = 8;
   localparam int SlotW      = 9;
   localparam int SumW       = 10;
   localparam int FracW      = 16;
   localparam int OctW       = 4;
   localparam int VoltW      = 20;
   localparam int QuotW      = 17;
   localparam int NumerW     = 25;
   localparam int CsrIndexW  = 2;

   localparam logic [DigitW-1:0] DigitMax     = 4'd9;
   localparam logic [CountW-1:0] CountMax     = 5'd16;
   localparam logic signed [VoltW-1:0] VoltLimit = 20'sd327680;

   localparam logic [63:0]       ScaleReset   = 64'd2527003170;
   localparam logic [CountW-1:0] NotesReset   = 5'd7;

   localparam logic [CsrIndexW-1:0] CsrScale = 2'd0;
   localparam logic [CsrIndexW-1:0] CsrNotes = 2'd1;

   // Result of one digit step of the walk.
   typedef struct packed {
      logic              bad;
      logic              hit_lo;
      logic              hit_hi;
      logic [SumW-1:0]   base_next;
      logic [TotalW-1:0] cum_next;
   } spq_step_type;

   // Divider handshake back to the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } spq_div_status_type;

endpackage

@@ hdl/scale_pitch_quantizer_top.sv @@
// Top level of the scale pitch quantizer: sequencer, registers and result word.
//
//   Channel   Direction  Ports                                   Word
//   req       in         req_valid, req_ready, req_voltage_in    one control voltage
//   rsp       out        rsp_valid, rsp_ready, rsp_voltage_out,  one quantized voltage
//                        rsp_status
//   csr       in         csr_valid, csr_ready, csr_index,        one register write
//                        csr_data
//
// A word goes from acceptance to result in steps: one pass over the interval digits
// to sum them, a multiply step, a second pass that stops at the chosen note, the
// bit-serial divider, a step to take the quotient and one to load the result register.
// An invalid scale skips the second pass and the divider.
// Reset is synchronous and restores the reset scale; no clearing pass is needed.
// The finished word sits in an output register, so a stalled rsp side holds only
// the final step; req_ready is low while a word is in work.
`timescale 1ns / 1ps

module scale_pitch_quantizer_top import spq_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic signed [VoltW-1:0] req_voltage_in,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [VoltW-1:0] rsp_voltage_out,
   output logic                    rsp_status,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CsrIndexW-1:0]    csr_index,
   input  logic [63:0]             csr_data
);

   // Sequencer states, one-hot.
   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SUM    = 6'b000010,
      ST_MUL    = 6'b000100,
      ST_PICK   = 6'b001000,
      ST_DIV    = 6'b010000,
      ST_FINISH = 6'b100000
   } spq_state_type;

   spq_state_type        state_ff, state_in;
   logic [63:0]          scale_ff, scale_in;
   logic [CountW-1:0]    notes_ff, notes_in;
   logic [OctW-1:0]      oct_ff,   oct_in;
   logic [FracW-1:0]     frac_ff,  frac_in;
   logic [CountW-1:0]    count_ff, count_in;
   logic [CountW-1:0]    idx_ff,   idx_in;
   logic [TotalW-1:0]    cum_ff,   cum_in;
   logic [TotalW-1:0]    total_ff, total_in;
   logic [SlotW-1:0]     base_ff,  base_in;
   logic [SlotW-1:0]     slot_ff,  slot_in;
   logic                 bad_ff,   bad_in;
   logic [QuotW-1:0]     quot_ff,  quot_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [VoltW-1:0]     rsp_volt_ff,  rsp_volt_in;
   logic                 rsp_status_ff, rsp_status_in;

   logic signed [VoltW-1:0] v_clamp;
   logic [DigitW-1:0]    digit;
   logic                 last_digit;
   logic [NumerW-1:0]    product;
   logic [TotalW-1:0]    pick_sel;
   logic                 div_start;
   logic [NumerW-1:0]    div_numer;
   logic [QuotW-1:0]     div_quot;
   spq_step_type         step;
   spq_div_status_type   div_status;
   logic                 req_take;
   logic                 rsp_load;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign req_take  = req_valid && req_ready;

   // Clamp to plus or minus five volts; the top nibble is then the floor octave.
   always_comb begin
      v_clamp = req_voltage_in;
      if (req_voltage_in > VoltLimit) begin
         v_clamp = VoltLimit;
      end else if (req_voltage_in < -VoltLimit) begin
         v_clamp = -VoltLimit;
      end
   end

   // The same digit walker serves the summing pass and the note search.
   assign digit      = scale_ff[{idx_ff[DigitW-1:0], 2'b00} +: DigitW];
   assign last_digit = ((idx_ff + 1'b1) == count_ff);

   spq_step u_step (
      .digit (digit),
      .slot  (slot_ff),
      .base  (base_ff),
      .cum   (cum_ff),
      .step  (step)
   );

   // Half-step slot: fraction times twice the total, upper bits kept.
   assign product = {{(NumerW-FracW){1'b0}}, frac_ff}
                  * {{(NumerW-TotalW-1){1'b0}}, cum_ff, 1'b0};

   assign div_numer = {pick_sel, {QuotW{1'b0}}} + {{(NumerW-TotalW){1'b0}}, total_ff};

   spq_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (div_numer),
      .denom    ({total_ff, 1'b0}),
      .status   (div_status),
      .quotient (div_quot)
   );

   always_comb begin
      state_in      = state_ff;
      scale_in      = scale_ff;
      notes_in      = notes_ff;
      oct_in        = oct_ff;
      frac_in       = frac_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      cum_in        = cum_ff;
      total_in      = total_ff;
      base_in       = base_ff;
      slot_in       = slot_ff;
      bad_in        = bad_ff;
      quot_in       = quot_ff;
      pick_sel      = total_ff;
      div_start     = 1'b0;
      rsp_load      = 1'b0;
      rsp_valid_in  = rsp_valid_ff;
      rsp_volt_in   = rsp_volt_ff;
      rsp_status_in = rsp_status_ff;

      if (csr_valid) begin
         case (csr_index)
            CsrScale: scale_in = csr_data;
            CsrNotes: notes_in = csr_data[CountW-1:0];
            default:  ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               oct_in   = v_clamp[VoltW-1 -: OctW];
               frac_in  = v_clamp[FracW-1:0];
               count_in = (notes_ff > CountMax) ? CountMax : notes_ff;
               idx_in   = '0;
               cum_in   = '0;
               bad_in   = 1'b0;
               // With no digits in use the sum stays zero and the scale is invalid.
               state_in = (notes_ff == '0) ? ST_MUL : ST_SUM;
            end
         end
         ST_SUM: begin
            cum_in = step.cum_next;
            bad_in = bad_ff || step.bad;
            idx_in = idx_ff + 1'b1;
            if (last_digit) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            total_in = cum_ff;
            if (bad_ff || (cum_ff == '0)) begin
               bad_in   = 1'b1;
               quot_in  = '0;
               state_in = ST_FINISH;
            end else begin
               slot_in  = product[NumerW-1 -: SlotW];
               idx_in   = '0;
               cum_in   = '0;
               base_in  = '0;
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            if (step.hit_lo) begin
               pick_sel  = cum_ff;
               div_start = 1'b1;
               state_in  = ST_DIV;
            end else if (step.hit_hi) begin
               pick_sel  = step.cum_next;
               div_start = 1'b1;
               state_in  = ST_DIV;
            end else if (last_digit) begin
               pick_sel  = total_ff;
               div_start = 1'b1;
               state_in  = ST_DIV;
            end else begin
               base_in = step.base_next[SlotW-1:0];
               cum_in  = step.cum_next;
               idx_in  = idx_ff + 1'b1;
            end
         end
         ST_DIV: begin
            if (div_status.done) begin
               quot_in  = div_quot;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_volt_in   = {oct_ff, {FracW{1'b0}}} + {{(VoltW-QuotW){1'b0}}, quot_ff};
         rsp_status_in = bad_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      oct_ff        <= oct_in;
      frac_ff       <= frac_in;
      count_ff      <= count_in;
      idx_ff        <= idx_in;
      cum_ff        <= cum_in;
      total_ff      <= total_in;
      base_ff       <= base_in;
      slot_ff       <= slot_in;
      bad_ff        <= bad_in;
      quot_ff       <= quot_in;
      rsp_volt_ff   <= rsp_volt_in;
      rsp_status_ff <= rsp_status_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         scale_ff     <= ScaleReset;
         notes_ff     <= NotesReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scale_ff     <= scale_in;
         notes_ff     <= notes_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_voltage_out = rsp_volt_ff;
   assign rsp_status      = rsp_status_ff;

   // The divider only finishes while the sequencer waits for it.
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide state");

   // An invalid scale yields a whole octave with no note fraction.
   a_bad_whole_octave: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff) |-> (rsp_volt_ff[FracW-1:0] == '0))
      else $error("invalid scale result carries a fraction");

   // Once a word is taken the block is busy on the next cycle.
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_take |=> !req_ready)
      else $error("ready stayed high after a word was accepted");

   // The note search never walks past the digits in use.
   a_pick_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PICK) |-> (idx_ff < count_ff))
      else $error("note search ran past the last digit");

   // The divider is started only from the note search.
   a_start_from_pick: assert property (@(posedge clock) disable iff (reset)
      div_start |-> ((state_ff == ST_PICK) && !div_status.busy))
      else $error("divider started outside the note search");

endmodule

@@ hdl/spq_step.sv @@
// Digit step unit: checks one interval digit and advances the running sums.
`timescale 1ns / 1ps

module spq_step import spq_pkg::*; (
   input  logic [DigitW-1:0] digit,
   input  logic [SlotW-1:0]  slot,
   input  logic [SlotW-1:0]  base,
   input  logic [TotalW-1:0] cum,
   output spq_step_type      step
);

   logic [SumW-1:0] lo_edge;
   logic [SumW-1:0] hi_edge;

   always_comb begin
      lo_edge = {1'b0, base} + {{(SumW-DigitW){1'b0}}, digit};
      hi_edge = lo_edge + {{(SumW-DigitW){1'b0}}, digit};
      step.bad       = (digit > DigitMax);
      step.hit_lo    = ({1'b0, slot} < lo_edge);
      step.hit_hi    = ({1'b0, slot} < hi_edge);
      step.base_next = hi_edge;
      step.cum_next  = cum + {{(TotalW-DigitW){1'b0}}, digit};
   end

endmodule

@@ hdl/spq_div.sv @@
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module spq_div import spq_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NumerW-1:0]   numer,
   input  logic [SlotW-1:0]    denom,
   output spq_div_status_type  status,
   output logic [QuotW-1:0]    quotient
);

   localparam int CntW = $clog2(NumerW);
   localparam logic [CntW-1:0] LastStep = CntW'(NumerW - 1);

   logic [SlotW-1:0]   rem_ff,   rem_in;
   logic [NumerW-1:0]  shift_ff, shift_in;
   logic [SlotW-1:0]   denom_ff, denom_in;
   logic [CntW-1:0]    cnt_ff,   cnt_in;
   logic               busy_ff,  busy_in;
   logic               done_ff,  done_in;
   logic [SlotW:0]     trial;
   logic               fits;

   always_comb begin
      trial    = {rem_ff, shift_ff[NumerW-1]};
      fits     = (trial >= {1'b0, denom_ff});
      rem_in   = rem_ff;
      shift_in = shift_ff;
      denom_in = denom_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         rem_in   = '0;
         shift_in = numer;
         denom_in = denom;
         cnt_in   = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in   = fits ? SlotW'(trial - {1'b0, denom_ff}) : trial[SlotW-1:0];
         shift_in = {shift_ff[NumerW-2:0], fits};
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == LastStep) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      shift_ff <= shift_in;
      denom_ff <= denom_in;
      cnt_ff   <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = shift_ff[QuotW-1:0];

endmodule
